@@ hw/rtl/vlss_pkg.sv @@
// ----------------------------------------------------------------------------
// vlss_pkg
// Shared types, codes and helpers for the vector load/store sequencer.
// ----------------------------------------------------------------------------
package vlss_pkg;

  localparam int unsigned ADDR_WIDTH_DEF = 64;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned CFG_IDX_W      = 4;

  typedef enum logic [1:0] {
    AM_UNIT    = 2'd0,
    AM_STRIDED = 2'd1,
    AM_INDEXED = 2'd2,
    AM_SPARE   = 2'd3
  } acc_mode_t;

  typedef enum logic [1:0] {
    OP_LOAD_U = 2'd0,
    OP_LOAD_S = 2'd1,
    OP_STORE  = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCESS_MODE = 4'd0,
    REG_ELEM_WIDTH  = 4'd1,
    REG_MEM_WIDTH   = 4'd2,
    REG_BASE_ADDR   = 4'd3,
    REG_STRIDE      = 4'd4,
    REG_UNMASKED    = 4'd5,
    REG_AGNOSTIC    = 4'd6,
    REG_OPERATION   = 4'd7
  } cfg_reg_t;

  localparam logic MODE_ISSUE    = 1'b0;
  localparam logic MODE_RESPONSE = 1'b1;

  // bit positions inside agnostic_policy
  localparam int unsigned AGN_MASK_BIT = 0;
  localparam int unsigned AGN_TAIL_BIT = 1;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
    logic [DATA_W-1:0] m;
    unique case (code)
      2'd0: m = 64'h0000_0000_0000_00ff;
      2'd1: m = 64'h0000_0000_0000_ffff;
      2'd2: m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic sign_bit(input logic [DATA_W-1:0] d, input logic [1:0] code);
    logic s;
    unique case (code)
      2'd0: s = d[7];
      2'd1: s = d[15];
      2'd2: s = d[31];
      default: s = d[63];
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/vlss_in_if.sv @@
// ----------------------------------------------------------------------------
// vlss_in_if
// Element issue / load response channel.
// ----------------------------------------------------------------------------
interface vlss_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        first_element;
  logic        in_tail;
  logic        mask_bit;
  logic [63:0] index_offset;
  logic [63:0] element_data;

  modport source (output valid, mode, first_element, in_tail, mask_bit,
                  index_offset, element_data, input ready);
  modport sink   (input valid, mode, first_element, in_tail, mask_bit,
                  index_offset, element_data, output ready);
endinterface

@@ hw/rtl/vlss_out_if.sv @@
// ----------------------------------------------------------------------------
// vlss_out_if
// Per-element result channel: memory request and register write-back.
// ----------------------------------------------------------------------------
interface vlss_out_if;
  logic        valid;
  logic        ready;
  logic        mem_enable;
  logic        mem_write;
  logic [63:0] mem_address;
  logic [1:0]  access_size_code;
  logic        reg_write;
  logic [63:0] data_out;

  modport source (output valid, mem_enable, mem_write, mem_address,
                  access_size_code, reg_write, data_out, input ready);
  modport sink   (input valid, mem_enable, mem_write, mem_address,
                  access_size_code, reg_write, data_out, output ready);
endinterface

@@ hw/rtl/vlss_cfg_if.sv @@
// ----------------------------------------------------------------------------
// vlss_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface vlss_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/vector_load_store_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// vector_load_store_sequencer_top
// Per-element address and data sequencer for vector loads and stores.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  in_bus   | in  | mode, first_element, in_tail, mask_bit, index_offset, element_data
//  out_bus  | out | mem_enable, mem_write, mem_address, access_size_code,
//           |     | reg_write, data_out
//  cfg_bus  | in  | index, data (always ready)
//
//  One beat per cycle unless out_bus stalls; each result is registered.
//  The running address is registered in run_r and feeds the next beat's address.
//  rst_n (synchronous) restores register defaults and clears the running address.
//  in_bus.ready is high while the result register is empty or being drained,
//  so a stalled output holds one result and back-pressures the input.
// ----------------------------------------------------------------------------
module vector_load_store_sequencer_top
  import vlss_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  vlss_in_if.sink    in_bus,
  vlss_out_if.source out_bus,
  vlss_cfg_if.sink   cfg_bus
);

  // configuration
  acc_mode_t             acc_mode_r;
  logic [1:0]            ewc_r;
  logic [1:0]            mwc_r;
  logic [ADDR_WIDTH-1:0] base_r;
  logic [ADDR_WIDTH-1:0] stride_r;
  logic                  unmasked_r;
  logic [1:0]            agn_r;
  op_t                   op_r;

  logic [ADDR_WIDTH-1:0] run_r, run_nxt;

  logic        out_valid_r;
  logic        mem_en_r, mem_en_nxt;
  logic        mem_wr_r, mem_wr_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [1:0]  size_r, size_nxt;
  logic        reg_wr_r, reg_wr_nxt;
  logic [63:0] dout_r, dout_nxt;

  logic                  in_acc;
  logic                  is_store;
  logic [ADDR_WIDTH-1:0] cur_base;
  logic [ADDR_WIDTH-1:0] cur_addr;
  logic [63:0]           idx_m;
  logic [63:0]           ld_val;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign is_store      = (op_r == OP_STORE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_mode_r <= AM_UNIT;
      ewc_r      <= 2'd0;
      mwc_r      <= 2'd0;
      base_r     <= '0;
      stride_r   <= '0;
      unmasked_r <= 1'b1;
      agn_r      <= 2'd0;
      op_r       <= OP_LOAD_U;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (cfg_bus.index)
        REG_ACCESS_MODE: acc_mode_r <= acc_mode_t'(cfg_bus.data[1:0]);
        REG_ELEM_WIDTH:  ewc_r      <= cfg_bus.data[1:0];
        REG_MEM_WIDTH:   mwc_r      <= cfg_bus.data[1:0];
        REG_BASE_ADDR:   base_r     <= cfg_bus.data[ADDR_WIDTH-1:0];
        REG_STRIDE:      stride_r   <= cfg_bus.data[ADDR_WIDTH-1:0];
        REG_UNMASKED:    unmasked_r <= cfg_bus.data[0];
        REG_AGNOSTIC:    agn_r      <= cfg_bus.data[1:0];
        REG_OPERATION:   op_r       <= op_t'(cfg_bus.data[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    size_nxt   = (acc_mode_r == AM_INDEXED) ? ewc_r : mwc_r;
    mem_en_nxt = 1'b0;
    mem_wr_nxt = 1'b0;
    addr_nxt   = '0;
    reg_wr_nxt = 1'b0;
    dout_nxt   = '0;

    cur_base = in_bus.first_element ? base_r : run_r;
    idx_m    = in_bus.index_offset & width_mask(mwc_r);
    cur_addr = (acc_mode_r == AM_INDEXED) ? base_r + idx_m[ADDR_WIDTH-1:0] : cur_base;
    run_nxt  = run_r;

    // load response: extend from access size, trim to element width
    ld_val = in_bus.element_data & width_mask(size_nxt);
    if (op_r == OP_LOAD_S && size_nxt != 2'd3 && sign_bit(in_bus.element_data, size_nxt))
      ld_val = ld_val | ~width_mask(size_nxt);

    if (in_bus.mode == MODE_RESPONSE) begin
      if (!is_store) begin
        reg_wr_nxt = 1'b1;
        dout_nxt   = ld_val & width_mask(ewc_r);
      end
    end else begin
      run_nxt = cur_base;
      if (in_bus.in_tail) begin
        if (!is_store && agn_r[AGN_TAIL_BIT]) begin
          reg_wr_nxt = 1'b1;
          dout_nxt   = width_mask(ewc_r);
        end
      end else begin
        if (unmasked_r || in_bus.mask_bit) begin
          mem_en_nxt = 1'b1;
          addr_nxt   = 64'(cur_addr);
          if (is_store) begin
            mem_wr_nxt = 1'b1;
            dout_nxt   = in_bus.element_data & width_mask(size_nxt);
          end
        end else if (!is_store && agn_r[AGN_MASK_BIT]) begin
          reg_wr_nxt = 1'b1;
          dout_nxt   = width_mask(ewc_r);
        end
        // masked-off body elements still advance the address
        unique case (acc_mode_r)
          AM_UNIT:    run_nxt = cur_base + ADDR_WIDTH'(64'd1 << size_nxt);
          AM_STRIDED: run_nxt = cur_base + stride_r;
          default:    run_nxt = cur_base;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc)
        run_r <= run_nxt;
      if (in_acc)
        out_valid_r <= 1'b1;
      else if (out_bus.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_en_r <= mem_en_nxt;
      mem_wr_r <= mem_wr_nxt;
      addr_r   <= addr_nxt;
      size_r   <= size_nxt;
      reg_wr_r <= reg_wr_nxt;
      dout_r   <= dout_nxt;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.mem_enable       = mem_en_r;
  assign out_bus.mem_write        = mem_wr_r;
  assign out_bus.mem_address      = addr_r;
  assign out_bus.access_size_code = size_r;
  assign out_bus.reg_write        = reg_wr_r;
  assign out_bus.data_out         = dout_r;

  a_no_addr_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !mem_en_r |-> addr_r == '0)
    else $error("address driven without a memory access");

  a_write_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mem_wr_r |-> mem_en_r)
    else $error("store without memory enable");

  a_access_or_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(mem_en_r && reg_wr_r))
    else $error("memory access and register write in one beat");

  a_resp_keeps_addr: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_bus.mode == MODE_RESPONSE |=> run_r == $past(run_r))
    else $error("load response moved the running address");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat produced no result");

endmodule
